// File: rtl/aes128_pkg.sv
package aes128_pkg;

    localparam int unsigned NUM_ROUNDS = 10;
    localparam int unsigned CFG_IDX_W  = 2;

    typedef logic [127:0] aes_block_t;
    typedef logic [7:0]   aes_byte_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_HI = 2'd0,
        REG_KEY_LO = 2'd1
    } cfg_reg_t;

    localparam aes_byte_t SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    // round constant used to derive the key of round r (index r-1)
    localparam aes_byte_t RCON [NUM_ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
    };

    // byte 0 is the most significant byte of the block
    function automatic aes_byte_t get_byte(input aes_block_t blk, input int unsigned idx);
        return blk[127 - 8*idx -: 8];
    endfunction

    function automatic aes_byte_t xtime(input aes_byte_t v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
    endfunction

    // byte i sits at row i % 4, column i / 4
    function automatic aes_block_t sub_shift(input aes_block_t s);
        aes_block_t t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(r + 4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
            end
        end
        return t;
    endfunction

    function automatic aes_block_t mix_columns(input aes_block_t s);
        aes_block_t t;
        aes_byte_t  a0, a1, a2, a3, b0, b1, b2, b3;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c + 1);
            a2 = get_byte(s, 4*c + 2);
            a3 = get_byte(s, 4*c + 3);
            b0 = xtime(a0);
            b1 = xtime(a1);
            b2 = xtime(a2);
            b3 = xtime(a3);
            t[127 - 32*c      -: 8] = b0 ^ a1 ^ b1 ^ a2 ^ a3;
            t[127 - 32*c - 8  -: 8] = a0 ^ b1 ^ a2 ^ b2 ^ a3;
            t[127 - 32*c - 16 -: 8] = a0 ^ a1 ^ b2 ^ a3 ^ b3;
            t[127 - 32*c - 24 -: 8] = a0 ^ b0 ^ a1 ^ a2 ^ b3;
        end
        return t;
    endfunction

    function automatic aes_block_t next_round_key(input aes_block_t rk, input aes_byte_t rcon);
        logic [31:0] w;
        aes_block_t  nk;
        w  = {SBOX[get_byte(rk, 13)] ^ rcon, SBOX[get_byte(rk, 14)],
              SBOX[get_byte(rk, 15)], SBOX[get_byte(rk, 12)]};
        nk = '0;
        for (int i = 0; i < 4; i++) begin
            w = w ^ rk[127 - 32*i -: 32];
            nk[127 - 32*i -: 32] = w;
        end
        return nk;
    endfunction

endpackage

// File: rtl/aes128_block_encrypt.sv
// Channel  Direction  Handshake              Payload
// s_       in         s_valid / s_ready      s_plain_hi, s_plain_lo
// m_       out        m_valid / m_ready      m_cipher_hi, m_cipher_lo
// cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Eleven register stages: the initial key addition, then one stage per round,
// each expanding its own round key from the key carried alongside the item.
// One item is taken per cycle while the output drains.
// Each stage loads when it is empty or its successor moves, so bubbles close
// up under an output stall and s_ready falls only when every stage is full.
// Reset (aresetn, synchronous) empties the pipeline and zeroes the key.
module aes128_block_encrypt
    import aes128_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [63:0]          s_plain_hi,
    input  logic [63:0]          s_plain_lo,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [63:0]          m_cipher_hi,
    output logic [63:0]          m_cipher_lo,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    localparam int unsigned NSTAGE = NUM_ROUNDS + 1;

    logic [63:0] key_hi_reg, key_lo_reg;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] load;
    aes_block_t        state_reg [NSTAGE];
    aes_block_t        rkey_reg  [NSTAGE];
    aes_block_t        state_next [NSTAGE];
    aes_block_t        rkey_next  [NSTAGE];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == REG_KEY_HI) begin
                key_hi_reg <= cfg_data;
            end
            if (cfg_index == REG_KEY_LO) begin
                key_lo_reg <= cfg_data;
            end
        end
    end

    // a stage loads when empty or when its own item moves on
    always_comb begin
        load[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    assign s_ready = load[0];

    always_comb begin
        rkey_next[0]  = {key_hi_reg, key_lo_reg};
        state_next[0] = {s_plain_hi, s_plain_lo} ^ rkey_next[0];
    end

    for (genvar k = 1; k < NSTAGE; k++) begin : g_round
        aes_block_t sub_s;
        always_comb begin
            sub_s        = sub_shift(state_reg[k-1]);
            rkey_next[k] = next_round_key(rkey_reg[k-1], RCON[k-1]);
            if (k == NSTAGE - 1) begin
                state_next[k] = sub_s ^ rkey_next[k];
            end else begin
                state_next[k] = mix_columns(sub_s) ^ rkey_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (load[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (load[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NSTAGE; k++) begin
            if (load[k]) begin
                state_reg[k] <= state_next[k];
                rkey_reg[k]  <= rkey_next[k];
            end
        end
    end

    assign m_valid     = valid_reg[NSTAGE-1];
    assign m_cipher_hi = state_reg[NSTAGE-1][127:64];
    assign m_cipher_lo = state_reg[NSTAGE-1][63:0];

    // input is refused only with the whole pipeline full
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> &valid_reg)
        else $error("input stalled with an empty stage");

    // a held result keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(state_reg[NSTAGE-1]))
        else $error("output item lost or changed while stalled");

    // an item in the first stage moves on when the next stage is free
    a_first_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[0] && load[1] |=> valid_reg[1])
        else $error("item dropped between first stages");

    // accepted item always lands in the first stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> valid_reg[0])
        else $error("accepted item not held");

endmodule

// File: verif/aes128_encrypt_checker.sv
`timescale 1ns / 1ps

module aes128_encrypt_checker
    import aes128_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [63:0]          s_plain_hi,
    input  logic [63:0]          s_plain_lo,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [63:0]          m_cipher_hi,
    input  logic [63:0]          m_cipher_lo,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    output int                   errors,
    output int                   pending
);

    localparam logic [7:0] GF_REDUCE   = 8'h1B;
    localparam logic [7:0] AFFINE_XOR  = 8'h63;
    localparam int         LAST_ROUND  = 10;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } cipher_t;

    logic [7:0]  sub_table [256];
    logic [63:0] key_hi = '0;
    logic [63:0] key_lo = '0;
    cipher_t     cipher_q [$];

    initial begin
        errors  = 0;
        pending = 0;
    end

    function automatic logic [7:0] gf_double(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? GF_REDUCE : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[0]) p ^= a;
            a = gf_double(a);
            b = b >> 1;
        end
        return p;
    endfunction

    // S-box built from the field inverse and the affine map, not taken from a table
    initial begin : build_sub_table
        logic [7:0] inv;
        for (int x = 0; x < 256; x++) begin
            inv = '0;
            for (int y = 1; y < 256; y++) begin
                if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
            end
            sub_table[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                         ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ AFFINE_XOR;
        end
    end

    function automatic cipher_t aes_encrypt_block(input logic [127:0] key,
                                                  input logic [127:0] plain);
        logic [7:0] st [16];
        logic [7:0] rk [16];
        logic [7:0] tmp [16];
        logic [7:0] w [4];
        logic [7:0] rc;
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] flat;
        for (int i = 0; i < 16; i++) begin
            st[i] = plain[127 - 8*i -: 8] ^ key[127 - 8*i -: 8];
            rk[i] = key[127 - 8*i -: 8];
        end
        rc = 8'h01;
        for (int rnd = 1; rnd <= LAST_ROUND; rnd++) begin
            // byte i is row i % 4, column i / 4; row r shifts left by r
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 4; r++) begin
                    tmp[r + 4*c] = sub_table[st[r + 4*((c + r) % 4)]];
                end
            end
            if (rnd != LAST_ROUND) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = tmp[4*c];
                    a1 = tmp[4*c + 1];
                    a2 = tmp[4*c + 2];
                    a3 = tmp[4*c + 3];
                    tmp[4*c]     = gf_double(a0 ^ a1) ^ a1 ^ a2 ^ a3;
                    tmp[4*c + 1] = gf_double(a1 ^ a2) ^ a2 ^ a3 ^ a0;
                    tmp[4*c + 2] = gf_double(a2 ^ a3) ^ a3 ^ a0 ^ a1;
                    tmp[4*c + 3] = gf_double(a3 ^ a0) ^ a0 ^ a1 ^ a2;
                end
            end
            w[0] = sub_table[rk[13]] ^ rc;
            w[1] = sub_table[rk[14]];
            w[2] = sub_table[rk[15]];
            w[3] = sub_table[rk[12]];
            for (int k = 0; k < 16; k++) begin
                rk[k]    = rk[k] ^ w[k % 4];
                w[k % 4] = rk[k];
            end
            rc = gf_double(rc);
            for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ rk[i];
        end
        for (int i = 0; i < 16; i++) flat[127 - 8*i -: 8] = st[i];
        return flat;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin : watch
        cipher_t want;
        if (!aresetn) begin
            key_hi = '0;
            key_lo = '0;
            cipher_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                cipher_q.push_back(aes_encrypt_block({key_hi, key_lo},
                                                     {s_plain_hi, s_plain_lo}));
            end
            if (m_valid && m_ready) begin
                if (cipher_q.size() == 0) begin
                    report_mismatch("unexpected item", m_cipher_hi, '0);
                end else begin
                    want = cipher_q.pop_front();
                    if (m_cipher_hi !== want.hi)
                        report_mismatch("cipher_hi", m_cipher_hi, want.hi);
                    if (m_cipher_lo !== want.lo)
                        report_mismatch("cipher_lo", m_cipher_lo, want.lo);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_KEY_HI: key_hi = cfg_data;
                    REG_KEY_LO: key_lo = cfg_data;
                    default: ;  // unmapped index, write dropped
                endcase
            end
        end
        pending <= cipher_q.size();
    end

endmodule

// File: verif/tb_aes128_block_encrypt.sv
`timescale 1ns / 1ps

module tb_aes128_block_encrypt;
    import aes128_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;
    localparam int NUM_PHASES       = 6;
    localparam int ITEMS_PER_PHASE  = 255;
    localparam int PIPE_LATENCY     = 11;
    localparam logic [63:0] ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [63:0]          s_plain_hi  = '0;
    logic [63:0]          s_plain_lo  = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [63:0]          m_cipher_hi;
    logic [63:0]          m_cipher_lo;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [63:0]          cfg_data    = '0;

    int errors;
    int pending;
    int tx_gap_max = 7;
    bit rx_calm    = 1'b0;

    always #1 aclk = ~aclk;

    aes128_block_encrypt dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_plain_hi  (s_plain_hi),
        .s_plain_lo  (s_plain_lo),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_cipher_hi (m_cipher_hi),
        .m_cipher_lo (m_cipher_lo),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    aes128_encrypt_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_plain_hi  (s_plain_hi),
        .s_plain_lo  (s_plain_lo),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_cipher_hi (m_cipher_hi),
        .m_cipher_lo (m_cipher_lo),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .pending     (pending)
    );

    // returns at the falling edge after the item is taken, valid left high
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
        int gap;
        gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_plain_hi <= hi;
        s_plain_lo <= lo;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
    endtask

    // stop sending and let the pipeline empty out
    task automatic drain_pipe();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (PIPE_LATENCY + 1) @(negedge aclk);
    endtask

    task automatic load_key(input logic [63:0] hi, input logic [63:0] lo,
                            input bit write_hi, input bit write_lo);
        if ($urandom_range(0, 1) == 0)
            write_reg($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
                      {$urandom, $urandom});
        if (write_hi) write_reg(REG_KEY_HI, hi);
        if (write_lo) write_reg(REG_KEY_LO, lo);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [63:0] rand_half();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return ONES;
            2:       return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // result side: random stall before each item, none while calm
    initial begin : result_sink
        int w;
        @(negedge aclk);
        forever begin
            w = rx_calm ? 0 : $urandom_range(0, 7);
            if (w > 0) begin
                m_ready <= 1'b0;
                repeat (w) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        logic [63:0] khi, klo;
        bit wh, wl;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // key still at its reset value
        send_block('0, '0);
        send_block(ONES, ONES);
        send_block(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
        send_block(64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF);
        drain_pipe();

        load_key(64'h0001_0203_0405_0607, 64'h0809_0A0B_0C0D_0E0F, 1'b1, 1'b1);
        send_block(64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF);
        send_block('0, '0);
        send_block(ONES, '0);
        send_block('0, ONES);
        send_block(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_block(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_block(64'h1B1B_1B1B_1B1B_1B1B, 64'h6363_6363_6363_6363);
        drain_pipe();

        // unmapped indexes must leave the key alone
        write_reg(REG_UNUSED_2, ONES);
        write_reg(REG_UNUSED_3, ONES);
        cfg_valid <= 1'b0;
        @(negedge aclk);
        send_block(64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF);
        send_block(64'h0001_0203_0405_0607, 64'h0809_0A0B_0C0D_0E0F);
        drain_pipe();

        load_key(ONES, ONES, 1'b1, 1'b1);
        send_block('0, '0);
        send_block(ONES, ONES);
        send_block(64'h8080_8080_8080_8080, 64'h0101_0101_0101_0101);
        drain_pipe();

        load_key(ONES, '0, 1'b0, 1'b1);
        tx_gap_max = 0;
        rx_calm    = 1'b1;
        send_block('0, '0);
        send_block(ONES, ONES);
        send_block(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
        drain_pipe();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            khi = rand_half();
            klo = rand_half();
            wh  = (ph == 0) || ($urandom_range(0, 5) != 0);
            wl  = (ph == 0) || !wh || ($urandom_range(0, 5) != 0);
            load_key(khi, klo, wh, wl);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 64 == 0) begin
                    tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
                    rx_calm    = ($urandom_range(0, 3) == 0);
                end
                if (n == ITEMS_PER_PHASE / 2 && (ph == 1 || $urandom_range(0, 2) == 0))
                    drain_pipe();
                send_block(rand_half(), rand_half());
            end
            drain_pipe();
        end

        repeat (PIPE_LATENCY * 2) @(negedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/aes128_pkg.sv
rtl/aes128_block_encrypt.sv
verif/aes128_encrypt_checker.sv
verif/tb_aes128_block_encrypt.sv
